>>> design/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg: shared definitions for the circular FIFO with reverse
// Operation and status codes, sequencer states and the index step direction.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // Width of the capacity register and of the item count.
  localparam int CAP_W   = 5;
  localparam int CNT_W   = 5;
  localparam int CAP_MAX = (2 ** CAP_W) - 1;

  // Capacity in use after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes carried in the input word.
  localparam logic [1:0] OP_ENQ = 2'd0;
  localparam logic [1:0] OP_DEQ = 2'd1;
  localparam logic [1:0] OP_REV = 2'd2;

  // Status codes returned in every result word.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SWAP_RD,
    S_SWAP_WLO,
    S_SWAP_WHI,
    S_FRONT_RD,
    S_FRONT_CAP
  } state_t;

  typedef enum logic {
    DIR_NEXT,
    DIR_PREV
  } step_dir_t;

endpackage

>>> design/cfr_ram.sv
// ----------------------------------------------------------------------------
// cfr_ram: generic RAM
// One write port and two read ports, both read ports registered.
// ----------------------------------------------------------------------------
module cfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> design/cfr_idx.sv
// ----------------------------------------------------------------------------
// cfr_idx: ring index step unit
// Moves a slot index one place forward or back, wrapping at the capacity.
// ----------------------------------------------------------------------------
module cfr_idx
  import cfr_pkg::*;
#(
  parameter int IDX_W = 4
) (
  input  logic [IDX_W-1:0] idx,
  input  logic [CAP_W-1:0] cap,
  input  step_dir_t        dir,
  output logic [IDX_W-1:0] res
);

  localparam int XW = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;

  logic [XW-1:0] ix;
  logic [XW-1:0] cx;
  logic [XW-1:0] inc;

  assign ix  = XW'(idx);
  assign cx  = XW'(cap);
  assign inc = ix + XW'(1);

  always_comb begin
    unique case (dir)
      DIR_NEXT: res = (inc >= cx) ? '0 : IDX_W'(inc);
      DIR_PREV: res = (ix == '0) ? IDX_W'(cx - XW'(1)) : IDX_W'(ix - XW'(1));
      default:  res = idx;
    endcase
  end

endmodule

>>> design/circular_fifo_with_reverse.sv
// ----------------------------------------------------------------------------
// circular_fifo_with_reverse: ring-buffer FIFO with in-place reversal
// Each accepted word passes through execute, front read and front capture;
// capture waits while the output register holds a result, and no new word
// is taken before it. A reverse adds floor(count / 2) swaps, each a read, a
// low and a high write, set by the one RAM write port. Reset (synchronous,
// rst_n low) empties the queue and sets capacity 16; entry store not cleared.
// ----------------------------------------------------------------------------
module circular_fifo_with_reverse
  import cfr_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration: capacity_in_use.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [CAP_W-1:0]                   cfg_data,
  // Input stream. tdata fields from bit 0: operation[1:0], data_in.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((WORD_BITS+2+7)/8)*8-1:0]   in_tdata,
  // Result stream. tdata fields from bit 0: status[1:0], data_out,
  // front_valid, front_value, item_count[4:0], full_flag.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [((2*WORD_BITS+9+7)/8)*8-1:0] out_tdata
);

  localparam int AW          = $clog2(DEPTH);
  localparam int OUT_W       = 2 * WORD_BITS + 9;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // Largest capacity the store allows, and the reset tail slot.
  localparam logic [CAP_W-1:0] DEPTH_SAT   = (DEPTH > CAP_MAX) ? CAP_W'(CAP_MAX)
                                                               : CAP_W'(DEPTH);
  localparam logic [CAP_W-1:0] CAP_RST_SAT = (DEPTH_SAT < CAP_RESET) ? DEPTH_SAT
                                                                     : CAP_RESET;
  localparam logic [AW-1:0]    TAIL_RST    = AW'(CAP_RST_SAT - 1'b1);

  // A capacity of zero acts as one; anything above the store size saturates.
  function automatic logic [CAP_W-1:0] cap_sat(input logic [CAP_W-1:0] raw);
    logic [CAP_W-1:0] c;
    if (raw == '0) begin
      c = CAP_W'(1);
    end else if (raw > DEPTH_SAT) begin
      c = DEPTH_SAT;
    end else begin
      c = raw;
    end
    return c;
  endfunction

  // Sequencer state and queue state.
  state_t              state_r, state_nxt;
  logic [CAP_W-1:0]    cap_r;
  logic [AW-1:0]       head_r, head_nxt;
  logic [AW-1:0]       tail_r, tail_nxt;
  logic [CNT_W-1:0]    occ_r, occ_nxt;

  // Working registers of the current word.
  logic [1:0]          op_r;
  logic [WORD_BITS-1:0] din_r;
  logic [1:0]          status_r, status_nxt;
  logic [WORD_BITS-1:0] dout_r, dout_nxt;
  logic [AW-1:0]       lo_r, lo_nxt;
  logic [AW-1:0]       hi_r, hi_nxt;
  logic [CNT_W-2:0]    n_r, n_nxt;
  logic [WORD_BITS-1:0] tmp_r, tmp_nxt;

  // Output register.
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_load;

  // RAM and step unit hookup.
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr_a, ram_raddr_b;
  logic [WORD_BITS-1:0] ram_rdata_a, ram_rdata_b;
  logic [AW-1:0]        step_idx, step_res;
  step_dir_t            step_dir;

  logic [CAP_W-1:0]     capc;
  logic [CAP_W-1:0]     cap_cfg;
  logic [AW-1:0]        cfg_tail;
  logic                 in_acc;
  logic                 cfg_acc;
  logic                 front_valid;
  logic [WORD_BITS-1:0] front_value;
  logic                 full_flag;

  assign capc     = cap_sat(cap_r);
  assign cap_cfg  = cap_sat(cfg_data);
  assign cfg_tail = AW'(cap_cfg - 1'b1);

  // The block takes a new word only while the sequencer is idle; a finished
  // result may still sit in the output register at that time.
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // The entry store. Port B normally looks at the head so that the front word
  // is ready once the operation has finished.
  cfr_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  // One index step unit, shared by the tail, the head and both swap pointers.
  cfr_idx #(
    .IDX_W (AW)
  ) u_step (
    .idx (step_idx),
    .cap (capc),
    .dir (step_dir),
    .res (step_res)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // A reverse of one word needs no swap at all.
        if (op_r == OP_REV && occ_r[CNT_W-1:1] != '0) begin
          state_nxt = S_SWAP_RD;
        end else begin
          state_nxt = S_FRONT_RD;
        end
      end
      S_SWAP_RD:  state_nxt = S_SWAP_WLO;
      S_SWAP_WLO: state_nxt = S_SWAP_WHI;
      S_SWAP_WHI: begin
        if (n_r == (CNT_W-1)'(1)) begin
          state_nxt = S_FRONT_RD;
        end else begin
          state_nxt = S_SWAP_RD;
        end
      end
      S_FRONT_RD: state_nxt = S_FRONT_CAP;
      S_FRONT_CAP: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath controls for each state.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = lo_r;
    ram_wdata   = ram_rdata_b;
    ram_raddr_a = head_r;
    ram_raddr_b = head_r;
    step_idx    = head_r;
    step_dir    = DIR_NEXT;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    occ_nxt     = occ_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    n_nxt       = n_r;
    tmp_nxt     = tmp_r;
    status_nxt  = status_r;
    dout_nxt    = dout_r;
    out_load    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        status_nxt = ST_DONE;
        dout_nxt   = '0;
      end
      S_EXEC: begin
        unique case (op_r)
          OP_ENQ: begin
            step_idx = tail_r;
            if (occ_r >= capc) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = step_res;
              ram_wdata = din_r;
              tail_nxt  = step_res;
              occ_nxt   = CNT_W'(occ_r + 1'b1);
            end
          end
          OP_DEQ: begin
            if (occ_r == '0) begin
              status_nxt = ST_EMPTY;
              dout_nxt   = '1;
            end else begin
              // Port A fetches the old head; the word is taken in the following state.
              head_nxt = step_res;
              occ_nxt  = CNT_W'(occ_r - 1'b1);
            end
          end
          OP_REV: begin
            if (occ_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              lo_nxt = head_r;
              hi_nxt = tail_r;
              n_nxt  = occ_r[CNT_W-1:1];
            end
          end
          default: begin
          end
        endcase
      end
      S_SWAP_RD: begin
        ram_raddr_a = lo_r;
        ram_raddr_b = hi_r;
      end
      S_SWAP_WLO: begin
        // The low slot takes the high word; the low word is parked.
        ram_we    = 1'b1;
        ram_waddr = lo_r;
        ram_wdata = ram_rdata_b;
        tmp_nxt   = ram_rdata_a;
        step_idx  = lo_r;
        lo_nxt    = step_res;
      end
      S_SWAP_WHI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_r;
        ram_wdata = tmp_r;
        step_idx  = hi_r;
        step_dir  = DIR_PREV;
        hi_nxt    = step_res;
        n_nxt     = (CNT_W-1)'(n_r - 1'b1);
      end
      S_FRONT_RD: begin
        if (op_r == OP_DEQ && status_r == ST_DONE) begin
          dout_nxt = ram_rdata_a;
        end
      end
      S_FRONT_CAP: begin
        out_load = !out_tvalid_r || out_tready;
      end
      default: begin
      end
    endcase
  end

  assign front_valid = (occ_r != '0);
  assign front_value = front_valid ? ram_rdata_b : '0;
  assign full_flag   = (occ_r == capc);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cap_r        <= CAP_RESET;
      head_r       <= '0;
      tail_r       <= TAIL_RST;
      occ_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        // A capacity write empties the queue; the stored words stay behind.
        cap_r  <= cfg_data;
        head_r <= '0;
        tail_r <= cfg_tail;
        occ_r  <= '0;
      end else begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        occ_r  <= occ_nxt;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_tdata[1:0];
      din_r <= in_tdata[WORD_BITS+1:2];
    end
    status_r <= status_nxt;
    dout_r   <= dout_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    n_r      <= n_nxt;
    tmp_r    <= tmp_nxt;
    if (out_load) begin
      out_tdata_r <= OUT_TDATA_W'({full_flag, occ_r, front_value, front_valid,
                                   dout_r, status_r});
    end
  end

`ifndef SYNTHESIS
  // The queue never holds more words than the capacity in use.
  a_occ_cap : assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= capc)
    else $error("occupancy above capacity");

  // An accepted word always starts execution on the next cycle.
  a_acc_exec : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_EXEC))
    else $error("accepted word did not start execution");

  // Swaps are only issued while at least one is left.
  a_swap_cnt : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWAP_RD) |-> (n_r != '0))
    else $error("swap issued with no swaps left");

  // A full rejection reports a full queue.
  a_full_rej : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[1:0] == ST_FULL) |-> out_tdata_r[2*WORD_BITS+8])
    else $error("full rejection without full flag");

  // An empty rejection reports no queued word.
  a_empty_rej : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[1:0] == ST_EMPTY) |->
      (out_tdata_r[2*WORD_BITS+7:2*WORD_BITS+3] == '0 && !out_tdata_r[WORD_BITS+2]))
    else $error("empty rejection with queued words");
`endif

endmodule
